@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

@@ rtl/lfd_pkg.sv @@
// Types and constants of the line finite-difference derivative block.
// No dependencies; used by the window, scale and top modules through scoped names.
`timescale 1ns / 1ps

package lfd_pkg;

	localparam int SAMPLE_W = 32;
	localparam int NUM_W    = 38;
	localparam int MAG_W    = 37;
	localparam int COUNT_W  = 17;
	localparam int POS_W    = 16;
	localparam int INV_W    = 32;
	localparam int HALF_W   = 16;
	localparam int PROD_W   = MAG_W + HALF_W;
	localparam int Q_W      = PROD_W + 1;
	localparam int BURST_N  = 3;
	localparam int BCNT_W   = 2;

	localparam logic [INV_W-1:0]  INV_RESET = 32'd5461;
	localparam logic [HALF_W-1:0] ROUND_HALF = 16'h8000;
	localparam logic [SAMPLE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [SAMPLE_W-1:0] NEG_LIMIT = 32'h8000_0000;

	typedef logic signed [NUM_W-1:0] num_t;

	typedef struct packed {
		num_t             num;
		logic [POS_W-1:0] pos;
		logic             fin;
		logic             bad;
	} entry_t;

endpackage

@@ rtl/lfd_window.sv @@
// Sample window, point counter and stencil numerators with a three-entry burst register.
// Depends on lfd_pkg.
`timescale 1ns / 1ps

module lfd_window #(
	parameter int MAX_LINE = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [lfd_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                 in_end,
	output logic                                 ent_valid,
	input  logic                                 ent_ready,
	output lfd_pkg::entry_t                      ent
);

	logic signed [lfd_pkg::SAMPLE_W-1:0] win_q [4];
	logic [lfd_pkg::COUNT_W-1:0]         cnt_q;
	lfd_pkg::entry_t                     bst_q [lfd_pkg::BURST_N];
	logic [lfd_pkg::BCNT_W-1:0]          bcnt_q;

	lfd_pkg::num_t x0, x1, x2, x3, x4;
	lfd_pkg::num_t inner_num;
	lfd_pkg::entry_t new_e [lfd_pkg::BURST_N];
	lfd_pkg::entry_t bad_e;
	logic [lfd_pkg::BCNT_W-1:0] new_n;
	logic [lfd_pkg::POS_W-1:0]  pos_i;
	logic accept, pop, over, early;

	assign ent_valid = (bcnt_q != '0);
	assign ent       = bst_q[0];
	assign pop       = ent_valid && ent_ready;
	assign in_ready  = (bcnt_q == '0) || ((bcnt_q == lfd_pkg::BCNT_W'(1)) && ent_ready);
	assign accept    = in_valid && in_ready;

	assign x0 = lfd_pkg::NUM_W'(win_q[0]);
	assign x1 = lfd_pkg::NUM_W'(win_q[1]);
	assign x2 = lfd_pkg::NUM_W'(win_q[2]);
	assign x3 = lfd_pkg::NUM_W'(win_q[3]);
	assign x4 = lfd_pkg::NUM_W'(in_sample);

	assign pos_i = cnt_q[lfd_pkg::POS_W-1:0];
	assign over  = (cnt_q >= lfd_pkg::COUNT_W'(MAX_LINE));
	assign early = (cnt_q < lfd_pkg::COUNT_W'(2));

	always_comb begin
		// Point i-2 is the first point, the second point, or an interior one.
		if (cnt_q == lfd_pkg::COUNT_W'(2)) begin
			inner_num = lfd_pkg::num_t'(6) *
				(lfd_pkg::num_t'(4) * x3 - lfd_pkg::num_t'(3) * x2 - x4);
		end else if (cnt_q == lfd_pkg::COUNT_W'(3)) begin
			inner_num = lfd_pkg::num_t'(6) * (x3 - x1);
		end else begin
			inner_num = x0 - lfd_pkg::num_t'(8) * x1 + lfd_pkg::num_t'(8) * x3 - x4;
		end
	end

	always_comb begin
		bad_e = '{num: '0, pos: '0, fin: 1'b1, bad: 1'b1};
		new_e[0] = '{num: inner_num, pos: pos_i - lfd_pkg::POS_W'(2), fin: 1'b0, bad: 1'b0};
		new_e[1] = '{num: lfd_pkg::num_t'(6) * (x4 - x2),
			pos: pos_i - lfd_pkg::POS_W'(1), fin: 1'b0, bad: 1'b0};
		new_e[2] = '{num: lfd_pkg::num_t'(6) *
			(lfd_pkg::num_t'(3) * x4 - lfd_pkg::num_t'(4) * x3 + x2),
			pos: pos_i, fin: 1'b1, bad: 1'b0};
		new_n = '0;
		if (over || (in_end && early)) begin
			new_e[0] = bad_e;
			new_n    = in_end ? lfd_pkg::BCNT_W'(1) : '0;
		end else if (!in_end) begin
			new_n = early ? '0 : lfd_pkg::BCNT_W'(1);
		end else begin
			new_n = lfd_pkg::BCNT_W'(3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				win_q[k] <= '0;
			end
			cnt_q  <= '0;
			bcnt_q <= '0;
		end else begin
			if (accept) begin
				if (in_end) begin
					for (int k = 0; k < 4; k++) begin
						win_q[k] <= '0;
					end
					cnt_q <= '0;
				end else begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= win_q[3];
					win_q[3] <= in_sample;
					if (!over) begin
						cnt_q <= cnt_q + lfd_pkg::COUNT_W'(1);
					end
				end
				bcnt_q <= new_n;
			end else if (pop) begin
				bcnt_q <= bcnt_q - lfd_pkg::BCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < lfd_pkg::BURST_N; k++) begin
				bst_q[k] <= new_e[k];
			end
		end else if (pop) begin
			bst_q[0] <= bst_q[1];
			bst_q[1] <= bst_q[2];
		end
	end

endmodule

@@ rtl/lfd_scale.sv @@
// Scaling by the Q16.16 reciprocal, rounding and saturation, with the output register.
// Depends on lfd_pkg.
`timescale 1ns / 1ps

module lfd_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lfd_pkg::INV_W-1:0]         cfg_wdata,
	input  logic                              ent_valid,
	output logic                              ent_ready,
	input  lfd_pkg::entry_t                   ent,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [lfd_pkg::SAMPLE_W-1:0] out_deriv,
	output logic [lfd_pkg::POS_W-1:0]         out_pos,
	output logic                              out_fin,
	output logic                              out_clip,
	output logic                              out_bad
);

	logic [lfd_pkg::INV_W-1:0]  inv_q;
	logic                       v_s2, v_s3;
	logic [lfd_pkg::PROD_W-1:0] phi_s2, plo_s2;
	logic                       neg_s2, fin_s2, bad_s2;
	logic [lfd_pkg::POS_W-1:0]  pos_s2;
	logic signed [lfd_pkg::SAMPLE_W-1:0] deriv_s3;
	logic [lfd_pkg::POS_W-1:0]  pos_s3;
	logic                       fin_s3, clip_s3, bad_s3;

	logic                       ready_s2, ready_s3, neg;
	logic [lfd_pkg::NUM_W-1:0]  neg_num;
	logic [lfd_pkg::MAG_W-1:0]  mag;
	logic [lfd_pkg::Q_W-1:0]    q, lim;
	logic [lfd_pkg::SAMPLE_W-1:0] qs;
	logic                       clip;

	assign ready_s3  = !v_s3 || out_ready;
	assign ready_s2  = !v_s2 || ready_s3;
	assign ent_ready = ready_s2;

	assign neg     = ent.num[lfd_pkg::NUM_W-1];
	assign neg_num = -ent.num;
	assign mag     = neg ? neg_num[lfd_pkg::MAG_W-1:0] : ent.num[lfd_pkg::MAG_W-1:0];

	always_comb begin
		q = lfd_pkg::Q_W'(phi_s2) +
			lfd_pkg::Q_W'((lfd_pkg::Q_W'(plo_s2) + lfd_pkg::Q_W'(lfd_pkg::ROUND_HALF))
				>> lfd_pkg::HALF_W);
		lim  = neg_s2 ? lfd_pkg::Q_W'(lfd_pkg::NEG_LIMIT) : lfd_pkg::Q_W'(lfd_pkg::POS_LIMIT);
		clip = (q > lim);
		qs   = clip ? lim[lfd_pkg::SAMPLE_W-1:0] : q[lfd_pkg::SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= lfd_pkg::INV_RESET;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			if (cfg_we) begin
				inv_q <= cfg_wdata;
			end
			if (ready_s2) begin
				v_s2 <= ent_valid;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && ent_valid) begin
			phi_s2 <= lfd_pkg::PROD_W'(mag) *
				lfd_pkg::PROD_W'(inv_q[lfd_pkg::INV_W-1:lfd_pkg::HALF_W]);
			plo_s2 <= lfd_pkg::PROD_W'(mag) *
				lfd_pkg::PROD_W'(inv_q[lfd_pkg::HALF_W-1:0]);
			neg_s2 <= neg;
			pos_s2 <= ent.pos;
			fin_s2 <= ent.fin;
			bad_s2 <= ent.bad;
		end
		if (ready_s3 && v_s2) begin
			deriv_s3 <= neg_s2 ? -$signed(qs) : $signed(qs);
			pos_s3   <= pos_s2;
			fin_s3   <= fin_s2;
			clip_s3  <= clip;
			bad_s3   <= bad_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_deriv = deriv_s3;
	assign out_pos   = pos_s3;
	assign out_fin   = fin_s3;
	assign out_clip  = clip_s3;
	assign out_bad   = bad_s3;

endmodule

@@ rtl/line_finite_difference_derivative.sv @@
// Results pass the burst, product and output registers. Throughput: one sample beat
// per cycle while m_axis_tready is high; a line end that flushes three points holds
// s_axis_tready low while the burst register drains, one point per cycle.
// Reset (arst_n low, asynchronous): window and point count clear, no beat is pending,
// and inv_twelve_h returns to 5461 (about 1/12 in Q16.16).
`timescale 1ns / 1ps

module line_finite_difference_derivative #(
	parameter int MAX_LINE = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: inv_twelve_h, unsigned Q16.16, written when cfg_we is high.
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	// Sample stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] sample (signed)
	input  logic        s_axis_tlast,   // line_end
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] derivative (signed), [47:32] position
	output logic        m_axis_tlast,   // final_res
	output logic [1:0]  m_axis_tuser    // [0] clipped, [1] bad_length
);

	// The front end keeps the last four samples and the count of samples in the
	// current line. Each accepted beat produces zero, one or three stencil
	// numerators, which wait in a small burst register and leave one per cycle
	// as the back end takes them. The back end multiplies the magnitude by the
	// two 16-bit halves of the reciprocal, registers both products, then
	// rounds, saturates and restores the sign into the output register.

	logic            ent_valid, ent_ready;
	lfd_pkg::entry_t ent;
	logic signed [lfd_pkg::SAMPLE_W-1:0] deriv;
	logic [lfd_pkg::POS_W-1:0] pos;
	logic            clip, bad;

	lfd_window #(
		.MAX_LINE(MAX_LINE)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample ($signed(s_axis_tdata)),
		.in_end    (s_axis_tlast),
		.ent_valid (ent_valid),
		.ent_ready (ent_ready),
		.ent       (ent)
	);

	lfd_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ent_valid (ent_valid),
		.ent_ready (ent_ready),
		.ent       (ent),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_deriv (deriv),
		.out_pos   (pos),
		.out_fin   (m_axis_tlast),
		.out_clip  (clip),
		.out_bad   (bad)
	);

	// Pack the result beat: derivative in the low word, position above it.
	assign m_axis_tdata = {pos, deriv};
	assign m_axis_tuser = {bad, clip};

endmodule

@@ rtl/lfd_checker.sv @@
// Port-level checks on the result stream of the derivative block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result beat stays offered.
	`ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// A bad-length report closes the line with a zero derivative at position zero.
	`ASSERT_IMP(a_bad_beat, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && (m_axis_tdata == 48'd0))

	// A bad-length report is never marked as saturated.
	`ASSERT_IMP(a_bad_noclip, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0])

	// A saturated derivative sits at one of the two 32-bit limits.
	`ASSERT_IMP(a_clip_limit, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[31:0] == 32'h7FFF_FFFF) || (m_axis_tdata[31:0] == 32'h8000_0000))

endmodule

bind line_finite_difference_derivative lfd_checker u_lfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
